/* src/bfds_pkg.sv */
// Shared types, widths and codes for the box-filter downscaler.
// Used by bfds_div, box_filter_image_downscale_unit and the testbench files.
`timescale 1ns / 1ps

package bfds_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int CFG_W   = 9;
    localparam int CFG_N   = 3;
    localparam int CFG_A_W = 2;
    localparam int COORD_W = 8;
    localparam int CH_N    = 4;
    localparam int CH_W    = 8;
    localparam int PIX_W   = CH_N * CH_W;
    localparam int CMD_W   = 2;

    localparam int PROD_W = 2 * CFG_W;
    localparam int CNT_W  = 2 * CFG_W;
    localparam int SUM_W  = CNT_W + CH_W;
    localparam int DIV_NW = SUM_W;
    localparam int DIV_DW = CNT_W;

    localparam logic [CFG_A_W-1:0] CFG_SRC_WIDTH   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_SRC_HEIGHT  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_TARGET_SIZE = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET_VALUE = 9'd64;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_REWIND = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

endpackage

/* src/bfds_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bfds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bfds_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on bfds_pkg for the request and response types.
`timescale 1ns / 1ps

module bfds_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfds_pkg::t_div_req  i_req,
    output bfds_pkg::t_div_rsp  o_rsp
);

    localparam int NW = bfds_pkg::DIV_NW;
    localparam int DW = bfds_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   c_trial;
    logic [DW:0]   c_diff;
    logic          c_ge;

    always_comb begin
        c_trial = {r_rem, r_quo[NW-1]};
        c_diff  = c_trial - {1'b0, r_den};
        c_ge    = (c_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], c_ge};
            r_rem <= c_ge ? c_diff[DW-1:0] : c_trial[DW-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

/* src/box_filter_image_downscale_unit.sv */
// Top level of the box-filter RGBA8 downscaler: command decode, query sequencer,
// box walk over the frame store. Depends on bfds_pkg, bfds_ram and bfds_div.
//
// Input channel (i_valid / o_stall) carries one command per beat: load the next
// source pixel at the load pointer, rewind the pointer, or query one destination
// pixel. Loads and rewinds give no result. A query gives one result beat on the
// output channel (o_valid / i_stall) with the averaged pixel, the destination size
// and a status bit.
// A query runs through the shared one-bit-per-cycle divider: one division for the
// destination size when scaling applies to a non-square source, four for the box
// edges, then one memory read per box pixel, then four divisions for the channel
// means when the box is not empty. Each division holds the sequencer until the
// divider is done; a query outside the destination skips edges, walk and means.
// The frame store read port sets the box walk at one pixel per cycle.
// One item is in flight at a time; o_stall is high while a query is at work.
// A finished result sits in the output register; if it is still stalled when the
// next query finishes, that query holds until the beat is taken.
// Reset clears the load pointer, sets all size registers to 64 and empties the
// output register; the frame store is not cleared and holds no valid data until
// loaded. Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata.
`timescale 1ns / 1ps

module box_filter_image_downscale_unit #(
    parameter int MAX_WIDTH  = bfds_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = bfds_pkg::MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bfds_pkg::CMD_W-1:0]    i_cmd,
    input  logic [bfds_pkg::PIX_W-1:0]    i_pixel_in,
    input  logic [bfds_pkg::COORD_W-1:0]  i_dest_x,
    input  logic [bfds_pkg::COORD_W-1:0]  i_dest_y,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bfds_pkg::PIX_W-1:0]    o_pixel_out,
    output logic [bfds_pkg::CFG_W-1:0]    o_dest_width,
    output logic [bfds_pkg::CFG_W-1:0]    o_dest_height,
    output logic                          o_status,

    input  logic                          i_cfg_we,
    input  logic [bfds_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [bfds_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int PW     = $clog2(DEPTH + 1);
    localparam int CFG_W  = bfds_pkg::CFG_W;
    localparam int PROD_W = bfds_pkg::PROD_W;
    localparam int CH_N   = bfds_pkg::CH_N;
    localparam int CH_W   = bfds_pkg::CH_W;
    localparam int PIX_W  = bfds_pkg::PIX_W;
    localparam int SUM_W  = bfds_pkg::SUM_W;
    localparam int CNT_W  = bfds_pkg::CNT_W;
    localparam int NW     = bfds_pkg::DIV_NW;
    localparam int DW     = bfds_pkg::DIV_DW;
    localparam int CHI_W  = $clog2(CH_N);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIZE,
        S_SDIV,
        S_CHECK,
        S_Y0,
        S_Y1,
        S_X0,
        S_X1,
        S_WALK,
        S_DRAIN,
        S_CSTART,
        S_CDIV,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [CFG_W-1:0]                r_src_width;
    logic [CFG_W-1:0]                r_src_height;
    logic [CFG_W-1:0]                r_target_size;
    logic [PW-1:0]                   r_load_ptr;

    logic [bfds_pkg::COORD_W-1:0]    r_x;
    logic [bfds_pkg::COORD_W-1:0]    r_y;
    logic [CFG_W-1:0]                r_dw;
    logic [CFG_W-1:0]                r_dh;
    logic [CFG_W-1:0]                r_y0;
    logic [CFG_W-1:0]                r_y1;
    logic [CFG_W-1:0]                r_x0;
    logic [CFG_W-1:0]                r_x1;
    logic [CFG_W-1:0]                r_sx;
    logic [CFG_W-1:0]                r_sy;
    logic [PW-1:0]                   r_row_base;
    logic                            r_rd_pend;
    logic [SUM_W-1:0]                r_sum [CH_N];
    logic [CNT_W-1:0]                r_count;
    logic [CHI_W-1:0]                r_ch;
    logic [PIX_W-1:0]                r_res_pix;
    logic                            r_res_st;

    logic                            r_out_valid;
    logic [PIX_W-1:0]                r_out_pix;
    logic [CFG_W-1:0]                r_out_dw;
    logic [CFG_W-1:0]                r_out_dh;
    logic                            r_out_st;

    logic                            c_in_acc;
    bfds_pkg::t_cmd                  c_cmd;
    logic [CFG_W-1:0]                c_w;
    logic [CFG_W-1:0]                c_h;
    logic                            c_scale;
    logic                            c_wide;
    logic [CFG_W-1:0]                c_qmin1;
    logic [CFG_W-1:0]                c_q9;
    logic                            c_out_range;
    logic                            c_walk_xend;
    logic                            c_walk_yend;
    logic [PROD_W-1:0]               c_y1_num;
    logic [PROD_W-1:0]               c_x1_num;

    logic                            c_we;
    logic [AW-1:0]                   c_raddr;
    logic [PIX_W-1:0]                c_rdata;

    bfds_pkg::t_div_req              c_div_req;
    bfds_pkg::t_div_rsp              c_div_rsp;

    bfds_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_load_ptr[AW-1:0]),
        .i_wdata (i_pixel_in),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    bfds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_div_req),
        .o_rsp   (c_div_rsp)
    );

    always_comb begin
        c_in_acc = i_valid && !o_stall;
        c_cmd    = bfds_pkg::t_cmd'(i_cmd);
        c_we     = c_in_acc && (c_cmd == bfds_pkg::CMD_LOAD) && (r_load_ptr < PW'(DEPTH));

        if (r_src_width == '0) begin
            c_w = CFG_W'(1);
        end else if (32'(r_src_width) > MAX_WIDTH) begin
            c_w = CFG_W'(MAX_WIDTH);
        end else begin
            c_w = r_src_width;
        end
        if (r_src_height == '0) begin
            c_h = CFG_W'(1);
        end else if (32'(r_src_height) > MAX_HEIGHT) begin
            c_h = CFG_W'(MAX_HEIGHT);
        end else begin
            c_h = r_src_height;
        end

        c_scale = (r_target_size != '0) && !((c_w <= r_target_size) && (c_h <= r_target_size));
        c_wide  = (c_w > c_h);

        c_q9    = c_div_rsp.quo[CFG_W-1:0];
        c_qmin1 = (c_div_rsp.quo == '0) ? CFG_W'(1) : c_q9;

        c_out_range = ({1'b0, r_x} >= r_dw) || ({1'b0, r_y} >= r_dh);

        c_y1_num = PROD_W'((PROD_W'(r_y) + 1'b1) * PROD_W'(c_h)) + PROD_W'(r_dh) - 1'b1;
        c_x1_num = PROD_W'((PROD_W'(r_x) + 1'b1) * PROD_W'(c_w)) + PROD_W'(r_dw) - 1'b1;

        c_walk_xend = (({1'b0, r_sx} + 1'b1) >= {1'b0, r_x1});
        c_walk_yend = (({1'b0, r_sy} + 1'b1) >= {1'b0, r_y1});

        c_raddr = AW'(r_row_base + PW'(r_sx));

        c_div_req.start = 1'b0;
        c_div_req.num   = '0;
        c_div_req.den   = '0;
        case (r_state)
            S_SIZE: begin
                c_div_req.start = c_scale && (c_w != c_h);
                c_div_req.num   = NW'((c_wide ? c_h : c_w) * r_target_size);
                c_div_req.den   = DW'(c_wide ? c_w : c_h);
            end
            S_CHECK: begin
                c_div_req.start = !c_out_range;
                c_div_req.num   = NW'(r_y * c_h);
                c_div_req.den   = DW'(r_dh);
            end
            S_Y0: begin
                c_div_req.start = c_div_rsp.done;
                c_div_req.num   = NW'(c_y1_num);
                c_div_req.den   = DW'(r_dh);
            end
            S_Y1: begin
                c_div_req.start = c_div_rsp.done;
                c_div_req.num   = NW'(r_x * c_w);
                c_div_req.den   = DW'(r_dw);
            end
            S_X0: begin
                c_div_req.start = c_div_rsp.done;
                c_div_req.num   = NW'(c_x1_num);
                c_div_req.den   = DW'(r_dw);
            end
            S_CSTART: begin
                c_div_req.start = (r_count != '0);
                c_div_req.num   = NW'(r_sum[r_ch]);
                c_div_req.den   = DW'(r_count);
            end
            default: begin
                c_div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_src_width   <= bfds_pkg::CFG_RESET_VALUE;
            r_src_height  <= bfds_pkg::CFG_RESET_VALUE;
            r_target_size <= bfds_pkg::CFG_RESET_VALUE;
            r_load_ptr    <= '0;
            r_rd_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bfds_pkg::CFG_SRC_WIDTH:   r_src_width   <= i_cfg_wdata;
                    bfds_pkg::CFG_SRC_HEIGHT:  r_src_height  <= i_cfg_wdata;
                    bfds_pkg::CFG_TARGET_SIZE: r_target_size <= i_cfg_wdata;
                    default: ;
                endcase
            end

            r_rd_pend <= (r_state == S_WALK);
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (c_in_acc) begin
                        case (c_cmd)
                            bfds_pkg::CMD_LOAD: begin
                                if (c_we) begin
                                    r_load_ptr <= r_load_ptr + 1'b1;
                                end
                            end
                            bfds_pkg::CMD_REWIND: begin
                                r_load_ptr <= '0;
                            end
                            bfds_pkg::CMD_QUERY: begin
                                r_state <= S_SIZE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SIZE: begin
                    if (!c_scale) begin
                        r_state <= S_CHECK;
                    end else if (c_w == c_h) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    if (c_div_rsp.done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= c_out_range ? S_OUT : S_Y0;
                end
                S_Y0: begin
                    if (c_div_rsp.done) begin
                        r_state <= S_Y1;
                    end
                end
                S_Y1: begin
                    if (c_div_rsp.done) begin
                        r_state <= S_X0;
                    end
                end
                S_X0: begin
                    if (c_div_rsp.done) begin
                        r_state <= S_X1;
                    end
                end
                S_X1: begin
                    if (c_div_rsp.done) begin
                        if ((r_x0 >= c_div_rsp.quo) || (r_y0 >= r_y1)) begin
                            r_state <= S_CSTART;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (c_walk_xend && c_walk_yend) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_CSTART;
                end
                S_CSTART: begin
                    r_state <= (r_count == '0) ? S_OUT : S_CDIV;
                end
                S_CDIV: begin
                    if (c_div_rsp.done) begin
                        r_state <= (r_ch == CHI_W'(CH_N - 1)) ? S_OUT : S_CSTART;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            for (int i = 0; i < CH_N; i++) begin
                r_sum[i] <= r_sum[i] + SUM_W'(c_rdata[i*CH_W +: CH_W]);
            end
            r_count <= r_count + 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                r_x <= i_dest_x;
                r_y <= i_dest_y;
            end
            S_SIZE: begin
                if (!c_scale) begin
                    r_dw <= c_w;
                    r_dh <= c_h;
                end else begin
                    r_dw <= r_target_size;
                    r_dh <= r_target_size;
                end
            end
            S_SDIV: begin
                if (c_div_rsp.done) begin
                    if (c_wide) begin
                        r_dh <= c_qmin1;
                    end else begin
                        r_dw <= c_qmin1;
                    end
                end
            end
            S_CHECK: begin
                r_res_pix <= '0;
                r_res_st  <= c_out_range ? bfds_pkg::ST_RANGE : bfds_pkg::ST_OK;
            end
            S_Y0: begin
                if (c_div_rsp.done) begin
                    r_y0 <= c_q9;
                end
            end
            S_Y1: begin
                if (c_div_rsp.done) begin
                    r_y1 <= (c_div_rsp.quo > NW'(c_h)) ? c_h : c_q9;
                end
            end
            S_X0: begin
                if (c_div_rsp.done) begin
                    r_x0 <= c_q9;
                end
            end
            S_X1: begin
                if (c_div_rsp.done) begin
                    r_x1       <= (c_div_rsp.quo > NW'(c_w)) ? c_w : c_q9;
                    r_sx       <= r_x0;
                    r_sy       <= r_y0;
                    r_row_base <= PW'(r_y0 * c_w);
                    r_ch       <= '0;
                    r_count    <= '0;
                    for (int i = 0; i < CH_N; i++) begin
                        r_sum[i] <= '0;
                    end
                end
            end
            S_WALK: begin
                if (c_walk_xend) begin
                    r_sx       <= r_x0;
                    r_sy       <= r_sy + 1'b1;
                    r_row_base <= r_row_base + PW'(c_w);
                end else begin
                    r_sx <= r_sx + 1'b1;
                end
            end
            S_CDIV: begin
                if (c_div_rsp.done) begin
                    r_res_pix[r_ch*CH_W +: CH_W] <= c_div_rsp.quo[CH_W-1:0];
                    r_ch                         <= r_ch + 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    r_out_pix <= r_res_pix;
                    r_out_dw  <= r_dw;
                    r_out_dh  <= r_dh;
                    r_out_st  <= r_res_st;
                end
            end
            default: ;
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_pixel_out   = r_out_pix;
    assign o_dest_width  = r_out_dw;
    assign o_dest_height = r_out_dh;
    assign o_status      = r_out_st;

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bfds_pkg::ST_RANGE)) |-> (o_pixel_out == '0))
        else $error("out-of-range beat carries a nonzero pixel");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_div_req.start |-> !c_div_rsp.busy)
        else $error("divider restarted while busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_in_acc && (c_cmd == bfds_pkg::CMD_QUERY)) |=> o_stall)
        else $error("query accepted without entering the sequencer");

    a_read_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ((r_state == S_WALK) || (r_state == S_DRAIN)))
        else $error("store read data pending outside the box walk");

endmodule

/* tb/sv/bfds_box_mean_checker.sv */
// Watches the command, result and register ports of the box-filter downscaler,
// predicts every query answer from its own copy of the frame store and registers.
// Depends on bfds_pkg.
`timescale 1ns / 1ps

module bfds_box_mean_checker
    import bfds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [PIX_W-1:0]   i_pixel_in,
    input  logic [COORD_W-1:0] i_dest_x,
    input  logic [COORD_W-1:0] i_dest_y,

    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [PIX_W-1:0]   i_pixel_out,
    input  logic [CFG_W-1:0]   i_dest_width,
    input  logic [CFG_W-1:0]   i_dest_height,
    input  logic               i_status,

    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,

    output int                 o_errors,
    output int                 o_pending
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic             status;
    } t_box_answer;

    logic [PIX_W-1:0] frame [0:STORE_DEPTH-1];
    int unsigned      load_ptr;
    logic [CFG_W-1:0] src_w_reg;
    logic [CFG_W-1:0] src_h_reg;
    logic [CFG_W-1:0] target_reg;
    t_box_answer      open_answers[$];

    function automatic int unsigned clamp_side(input logic [CFG_W-1:0] raw,
                                               input int unsigned limit);
        if (raw == 0) return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    function automatic int unsigned scale_side(input int unsigned side, other, limit);
        int unsigned d;
        d = (side > other) ? limit : (side * limit) / other;
        return (d == 0) ? 1 : d;
    endfunction

    function automatic t_box_answer average_box(input logic [COORD_W-1:0] qx, qy);
        int unsigned w, h, t, dw, dh, x0, x1, y0, y1, cnt;
        int unsigned sums [CH_N];
        logic [PIX_W-1:0] pix;
        t_box_answer answer;
        w = clamp_side(src_w_reg, MAX_WIDTH);
        h = clamp_side(src_h_reg, MAX_HEIGHT);
        t = target_reg;
        if (t == 0 || (w <= t && h <= t)) begin
            dw = w;
            dh = h;
        end else begin
            dw = scale_side(w, h, t);
            dh = scale_side(h, w, t);
        end
        answer = '0;
        answer.width = dw[CFG_W-1:0];
        answer.height = dh[CFG_W-1:0];
        if (qx >= dw || qy >= dh) begin
            answer.status = ST_RANGE;
            return answer;
        end
        y0 = qy * h / dh;
        y1 = ((qy + 1) * h + dh - 1) / dh;
        if (y1 > h) y1 = h;
        x0 = qx * w / dw;
        x1 = ((qx + 1) * w + dw - 1) / dw;
        if (x1 > w) x1 = w;
        for (int ch = 0; ch < CH_N; ch++) sums[ch] = 0;
        cnt = 0;
        for (int unsigned sy = y0; sy < y1; sy++) begin
            for (int unsigned sx = x0; sx < x1; sx++) begin
                pix = frame[sy * w + sx];
                for (int ch = 0; ch < CH_N; ch++) sums[ch] += pix[CH_W*ch +: CH_W];
                cnt++;
            end
        end
        if (cnt != 0) begin
            for (int ch = 0; ch < CH_N; ch++) answer.pixel[CH_W*ch +: CH_W] = sums[ch] / cnt;
        end
        answer.status = ST_OK;
        return answer;
    endfunction

    task automatic compare_field(input string field, input logic [PIX_W-1:0] want, got);
        if (want !== got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_box_answer want;
        if (!i_rst_n) begin
            load_ptr = 0;
            src_w_reg = CFG_RESET_VALUE;
            src_h_reg = CFG_RESET_VALUE;
            target_reg = CFG_RESET_VALUE;
            open_answers.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SRC_WIDTH:   src_w_reg = i_cfg_wdata;
                    CFG_SRC_HEIGHT:  src_h_reg = i_cfg_wdata;
                    CFG_TARGET_SIZE: target_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_cmd)
                    CMD_LOAD: begin
                        if (load_ptr < STORE_DEPTH) begin
                            frame[load_ptr] = i_pixel_in;
                            load_ptr++;
                        end
                    end
                    CMD_REWIND: load_ptr = 0;
                    CMD_QUERY:  open_answers.push_back(average_box(i_dest_x, i_dest_y));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (open_answers.size() == 0) begin
                    o_errors++;
                    $display("%0t: result beat with no query waiting, expected none, actual %h",
                             $time, i_pixel_out);
                end else begin
                    want = open_answers.pop_front();
                    compare_field("pixel_out", want.pixel, i_pixel_out);
                    compare_field("dest_width", want.width, i_dest_width);
                    compare_field("dest_height", want.height, i_dest_height);
                    compare_field("status", want.status, i_status);
                end
            end
        end
        o_pending = open_answers.size();
    end

endmodule

/* tb/sv/tb_box_filter_image_downscale_unit.sv */
// Stimulus and verdict for box_filter_image_downscale_unit: fills a prefix of the
// frame store, runs directed and random image phases. Depends on bfds_pkg and
// bfds_box_mean_checker.
`timescale 1ns / 1ps

module tb_box_filter_image_downscale_unit;
    import bfds_pkg::*;

    localparam int     RESET_CYCLES  = 10;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     RANDOM_ITEMS  = 1500;
    localparam int     PREFIX_PIXELS = 256;
    localparam longint CYCLE_LIMIT   = 5_000_000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} t_stall_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [CMD_W-1:0]   i_cmd = '0;
    logic [PIX_W-1:0]   i_pixel_in = '0;
    logic [COORD_W-1:0] i_dest_x = '0;
    logic [COORD_W-1:0] i_dest_y = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [PIX_W-1:0]   o_pixel_out;
    logic [CFG_W-1:0]   o_dest_width;
    logic [CFG_W-1:0]   o_dest_height;
    logic               o_status;
    logic               i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;

    int          mismatches;
    int          pending;
    longint      cycle_count = 0;
    int unsigned commands_sent = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int unsigned img_w = 64;
    int unsigned img_h = 64;
    int unsigned img_t = 64;

    box_filter_image_downscale_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_pixel_in    (i_pixel_in),
        .i_dest_x      (i_dest_x),
        .i_dest_y      (i_dest_y),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_dest_width  (o_dest_width),
        .o_dest_height (o_dest_height),
        .o_status      (o_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    bfds_box_mean_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_cmd         (i_cmd),
        .i_pixel_in    (i_pixel_in),
        .i_dest_x      (i_dest_x),
        .i_dest_y      (i_dest_y),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_pixel_out   (o_pixel_out),
        .i_dest_width  (o_dest_width),
        .i_dest_height (o_dest_height),
        .i_status      (o_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_errors      (mismatches),
        .o_pending     (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_box_filter_image_downscale_unit: errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 96);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_stall = 1'b0;
            STALL_LIGHT: i_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall = ($urandom_range(0, 3) != 0);
            default:     i_stall = stall_left[4];
        endcase
    end

    function automatic int unsigned clamp_side(input logic [CFG_W-1:0] raw);
        if (raw == 0) return 1;
        return (raw > MAX_WIDTH) ? MAX_WIDTH : raw;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_side();
        case ($urandom_range(0, 15))
            0:       return MAX_WIDTH;
            1:       return $urandom_range(0, 511);
            2:       return 1;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned side);
        int unsigned bound;
        bound = (img_t == 0 || img_t > side) ? side : img_t;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, (bound > 256) ? 255 : bound - 1);
    endfunction

    // Called and returns at a falling edge; valid stays high across a burst.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [PIX_W-1:0] pix,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_cmd = cmd;
        i_pixel_in = pix;
        i_dest_x = x;
        i_dest_y = y;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        burst_left--;
        if (cmd != CMD_UNUSED) commands_sent++;
    endtask

    task automatic query(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        send_beat(CMD_QUERY, $urandom, x, y);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_image(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] t);
        wait_drained();
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_TARGET_SIZE, t);
        img_w = clamp_side(w);
        img_h = clamp_side(h);
        img_t = t;
    endtask

    initial begin
        int unsigned random_start;
        int unsigned n;
        logic [CFG_W-1:0] side_a;
        logic [CFG_W-1:0] side_b;
        logic [CFG_W-1:0] tgt;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fill the part of the store that every image below reads
        repeat (PREFIX_PIXELS) send_beat(CMD_LOAD, rand_pixel(), $urandom, $urandom);

        set_image(256, 1, 0);
        query(0, 0);
        query(255, 0);
        query(128, 7);
        set_image(256, 1, 1);
        query(0, 0);
        query(1, 0);
        set_image(2, 2, 1);
        send_beat(CMD_REWIND, '1, '1, '1);
        send_beat(CMD_LOAD, 32'hFFFF_FFFF, 0, 0);
        send_beat(CMD_LOAD, 32'hFFFF_FFFF, 0, 0);
        send_beat(CMD_LOAD, 32'hFFFF_FFFF, 0, 0);
        send_beat(CMD_LOAD, 32'h0000_0000, 0, 0);
        query(0, 0);
        query(0, 1);
        // reread the same pixels with a new row stride
        set_image(1, 4, 0);
        query(0, 3);
        set_image(0, 511, 256);
        query(0, 255);
        query(1, 0);
        set_image(300, 0, 3);
        query(2, 0);
        query(0, 1);
        query(255, 255);
        send_beat(CMD_UNUSED, '1, '1, '1);
        query(1, 0);
        set_image(511, 511, 511);
        query(255, 0);

        random_start = commands_sent;
        while (commands_sent < random_start + RANDOM_ITEMS) begin
            side_a = pick_side();
            side_b = pick_side();
            if (clamp_side(side_a) * clamp_side(side_b) > PREFIX_PIXELS) begin
                side_b = $urandom_range(1, PREFIX_PIXELS / clamp_side(side_a));
            end
            case ($urandom_range(0, 7))
                0:       tgt = 0;
                1:       tgt = 1;
                2:       tgt = $urandom_range(0, 511);
                default: tgt = $urandom_range(1, clamp_side(side_a) + clamp_side(side_b));
            endcase
            set_image(side_a, side_b, tgt);
            if ($urandom_range(0, 7) != 0) begin
                send_beat(CMD_REWIND, $urandom, $urandom, $urandom);
                n = img_w * img_h;
                if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
                repeat (n) send_beat(CMD_LOAD, rand_pixel(), $urandom, $urandom);
            end
            repeat ($urandom_range(4, 24)) begin
                case ($urandom_range(0, 19))
                    0:       send_beat(CMD_UNUSED, $urandom, $urandom, $urandom);
                    1:       send_beat(CMD_REWIND, $urandom, $urandom, $urandom);
                    2:       send_beat(CMD_LOAD, rand_pixel(), $urandom, $urandom);
                    default: query(pick_coord(img_w), pick_coord(img_h));
                endcase
            end
        end

        wait_drained();
        if (mismatches == 0 && pending == 0) begin
            $display("tb_box_filter_image_downscale_unit: clean");
        end else begin
            $display("tb_box_filter_image_downscale_unit: errors");
        end
        $finish;
    end

endmodule
